/* hw/rtl/ebalu_pkg.sv */
// Shared types and constants for the eight-bit ALU with flags.
`timescale 1ns / 1ps
`default_nettype none

package ebalu_pkg;

    // Operation codes carried on the input tuser
    typedef enum logic [4:0] {
        ACT_ADD  = 5'd0,
        ACT_ADC  = 5'd1,
        ACT_SUB  = 5'd2,
        ACT_CP   = 5'd3,
        ACT_AND  = 5'd4,
        ACT_OR   = 5'd5,
        ACT_XOR  = 5'd6,
        ACT_INC  = 5'd7,
        ACT_DEC  = 5'd8,
        ACT_DAA  = 5'd9,
        ACT_CPL  = 5'd10,
        ACT_SCF  = 5'd11,
        ACT_RLCA = 5'd12,
        ACT_RRA  = 5'd13,
        ACT_RR   = 5'd14,
        ACT_SRL  = 5'd15,
        ACT_SWAP = 5'd16
    } action_t;

    // Z, N, H, C flag group
    typedef struct packed {
        logic carry;
        logic half;
        logic subtract;
        logic zero;
    } flags_t;

    // Decimal adjust constants
    localparam logic [7:0] DAA_LOW_ADJ  = 8'h06;
    localparam logic [7:0] DAA_HIGH_ADJ = 8'h60;
    localparam logic [7:0] DAA_HIGH_MAX = 8'h99;
    localparam logic [3:0] DAA_LOW_MAX  = 4'h9;

    localparam int DATA_W = 8;

endpackage

`default_nettype wire

/* hw/rtl/ebalu_core.sv */
// Combinational datapath: one operation on one byte plus flag update.
`timescale 1ns / 1ps
`default_nettype none

module ebalu_core
    import ebalu_pkg::*;
(
    input  wire logic [4:0]        action,
    input  wire logic [DATA_W-1:0] acc_in,
    input  wire logic [DATA_W-1:0] operand,
    input  wire flags_t            flags_in,
    output logic [DATA_W-1:0]      result,
    output logic                   write_result,
    output flags_t                 flags_out
);

    logic       carry_sel;
    logic [8:0] add_sum;
    logic [4:0] add_half;
    logic [8:0] sub_diff;
    logic [4:0] sub_half;
    logic       daa_low;
    logic       daa_high;
    logic [7:0] daa_adj;
    logic [7:0] daa_res;

    // Shared adder and subtractor with nibble carries
    always_comb
    begin
        carry_sel = (action_t'(action) == ACT_ADC) ? flags_in.carry : 1'b0;
        add_sum   = {1'b0, acc_in} + {1'b0, operand} + {8'd0, carry_sel};
        add_half  = {1'b0, acc_in[3:0]} + {1'b0, operand[3:0]} + {4'd0, carry_sel};
        sub_diff  = {1'b0, acc_in} - {1'b0, operand};
        sub_half  = {1'b0, acc_in[3:0]} - {1'b0, operand[3:0]};
    end

    // Decimal adjust after add or subtract
    always_comb
    begin
        if (flags_in.subtract)
        begin
            daa_low  = flags_in.half;
            daa_high = flags_in.carry;
        end
        else
        begin
            daa_low  = flags_in.half || (acc_in[3:0] > DAA_LOW_MAX);
            daa_high = flags_in.carry || (acc_in > DAA_HIGH_MAX);
        end
        daa_adj = (daa_low ? DAA_LOW_ADJ : 8'h00) | (daa_high ? DAA_HIGH_ADJ : 8'h00);
        daa_res = flags_in.subtract ? (acc_in - daa_adj) : (acc_in + daa_adj);
    end

    // Decode the operation; untouched flags pass through
    always_comb
    begin
        result       = acc_in;
        write_result = 1'b1;
        flags_out    = flags_in;
        unique case (action_t'(action))
            ACT_ADD, ACT_ADC:
            begin
                result             = add_sum[7:0];
                flags_out.subtract = 1'b0;
                flags_out.half     = add_half[4];
                flags_out.carry    = add_sum[8];
                flags_out.zero     = (add_sum[7:0] == 8'd0);
            end
            ACT_SUB, ACT_CP:
            begin
                result             = sub_diff[7:0];
                flags_out.zero     = (sub_diff[7:0] == 8'd0);
                flags_out.subtract = 1'b1;
                flags_out.half     = sub_half[4];
                flags_out.carry    = sub_diff[8];
                if (action_t'(action) == ACT_CP)
                begin
                    result       = acc_in;
                    write_result = 1'b0;
                end
            end
            ACT_AND:
            begin
                result    = acc_in & operand;
                flags_out = '{carry: 1'b0, half: 1'b1, subtract: 1'b0,
                              zero: ((acc_in & operand) == 8'd0)};
            end
            ACT_OR:
            begin
                result    = acc_in | operand;
                flags_out = '{carry: 1'b0, half: 1'b0, subtract: 1'b0,
                              zero: ((acc_in | operand) == 8'd0)};
            end
            ACT_XOR:
            begin
                result    = acc_in ^ operand;
                flags_out = '{carry: 1'b0, half: 1'b0, subtract: 1'b0,
                              zero: ((acc_in ^ operand) == 8'd0)};
            end
            ACT_INC:
            begin
                result             = operand + 8'd1;
                flags_out.zero     = (operand == 8'hFF);
                flags_out.subtract = 1'b0;
                flags_out.half     = (operand[3:0] == 4'hF);
            end
            ACT_DEC:
            begin
                result             = operand - 8'd1;
                flags_out.zero     = (operand == 8'h01);
                flags_out.subtract = 1'b1;
                flags_out.half     = (operand[3:0] == 4'h0);
            end
            ACT_DAA:
            begin
                result         = daa_res;
                flags_out.zero = (daa_res == 8'd0);
                flags_out.half = 1'b0;
                if (!flags_in.subtract)
                begin
                    flags_out.carry = daa_high;
                end
            end
            ACT_CPL:
            begin
                result             = ~acc_in;
                flags_out.subtract = 1'b1;
                flags_out.half     = 1'b1;
            end
            ACT_SCF:
            begin
                write_result       = 1'b0;
                flags_out.subtract = 1'b0;
                flags_out.half     = 1'b0;
                flags_out.carry    = 1'b1;
            end
            ACT_RLCA:
            begin
                result    = {acc_in[6:0], acc_in[7]};
                flags_out = '{carry: acc_in[7], half: 1'b0, subtract: 1'b0, zero: 1'b0};
            end
            ACT_RRA:
            begin
                result    = {flags_in.carry, acc_in[7:1]};
                flags_out = '{carry: acc_in[0], half: 1'b0, subtract: 1'b0, zero: 1'b0};
            end
            ACT_RR:
            begin
                result    = {flags_in.carry, operand[7:1]};
                flags_out = '{carry: operand[0], half: 1'b0, subtract: 1'b0,
                              zero: ({flags_in.carry, operand[7:1]} == 8'd0)};
            end
            ACT_SRL:
            begin
                result    = {1'b0, operand[7:1]};
                flags_out = '{carry: operand[0], half: 1'b0, subtract: 1'b0,
                              zero: (operand[7:1] == 7'd0)};
            end
            ACT_SWAP:
            begin
                result    = {operand[3:0], operand[7:4]};
                flags_out = '{carry: 1'b0, half: 1'b0, subtract: 1'b0,
                              zero: (operand == 8'd0)};
            end
            default:
            begin
                // Unused codes: no write, flags unchanged
                result       = acc_in;
                write_result = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/eight_bit_alu_with_flags.sv */
// Top level: input register, ALU datapath and result register on stream ports.
// Path: input word captured in the input register, then the ALU result captured in the result register.
// Throughput: one word per cycle while the output is taken; the result register and the input register
// each advance whenever the stage after them is empty or being drained.
// Reset: rst_n asynchronous active low clears both stage valid bits; the data registers are not reset,
// and s_axis_tready is high as soon as both valid bits are clear.
`timescale 1ns / 1ps
`default_nettype none

module eight_bit_alu_with_flags
    import ebalu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [7:0] acc_in, [15:8] operand, [16] zero_in, [17] subtract_in,
    // [18] half_in, [19] carry_in, [23:20] zero
    input  wire logic [23:0] s_axis_tdata,
    // [4:0] action
    input  wire logic [4:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] result, [8] write_result, [9] zero_out, [10] subtract_out,
    // [11] half_out, [12] carry_out, [15:13] zero
    output logic [15:0]      m_axis_tdata
);

    logic              in_valid_reg;
    logic [4:0]        action_reg;
    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] operand_reg;
    flags_t            flags_in_reg;

    logic              out_valid_reg;
    logic [DATA_W-1:0] result_reg;
    logic              write_reg;
    flags_t            flags_out_reg;

    logic [DATA_W-1:0] result_next;
    logic              write_next;
    flags_t            flags_next;
    logic              out_adv;
    logic              in_adv;

    // Stage enables
    assign out_adv       = !out_valid_reg || m_axis_tready;
    assign in_adv        = !in_valid_reg || out_adv;
    assign s_axis_tready = in_adv;

    // Capture the incoming word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_adv)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_adv && s_axis_tvalid)
        begin
            action_reg   <= s_axis_tuser;
            acc_reg      <= s_axis_tdata[7:0];
            operand_reg  <= s_axis_tdata[15:8];
            flags_in_reg <= '{carry: s_axis_tdata[19], half: s_axis_tdata[18],
                              subtract: s_axis_tdata[17], zero: s_axis_tdata[16]};
        end
    end

    ebalu_core u_core (
        .action       (action_reg),
        .acc_in       (acc_reg),
        .operand      (operand_reg),
        .flags_in     (flags_in_reg),
        .result       (result_next),
        .write_result (write_next),
        .flags_out    (flags_next)
    );

    // Hold the result word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && in_valid_reg)
        begin
            result_reg    <= result_next;
            write_reg     <= write_next;
            flags_out_reg <= flags_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, flags_out_reg.carry, flags_out_reg.half,
                            flags_out_reg.subtract, flags_out_reg.zero,
                            write_reg, result_reg};

endmodule

`default_nettype wire

/* test/tb_eight_bit_alu_with_flags.sv */
// Self-checking testbench for the eight-bit ALU with flags on stream ports.
`timescale 1ns / 1ps
`default_nettype none

module tb_eight_bit_alu_with_flags;
    import ebalu_pkg::*;

    localparam int          CLK_PERIOD    = 20;
    localparam int          RESET_CYCLES  = 12;
    localparam int          RANDOM_WORDS  = 1126;
    localparam int          LONG_HOLD     = 80;
    localparam int          HOLD_AT_WORD  = 250;
    localparam int          DRAIN_AT_WORD = 700;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          STALL_LIMIT   = 2000;
    localparam int          REPORT_MAX    = 10;
    localparam logic [4:0]  ACT_SPARE_LO  = 5'd17;
    localparam logic [4:0]  ACT_SPARE_HI  = 5'd31;

    // One ALU outcome: new byte, write enable and new flags
    typedef struct packed {
        logic [7:0] value;
        logic       write_en;
        flags_t     flags;
    } outcome_t;

    // Predicts each ALU outcome and matches it against the block's output
    class alu_result_ledger;
        outcome_t awaited[$];
        int       mismatches;
        int       results_seen;
        int       words_in;
        int       spare_codes;
        bit       op_seen[32];

        function outcome_t alu_predict(logic [4:0] code, logic [7:0] a, logic [7:0] b,
                                       flags_t f);
            outcome_t   o;
            logic [8:0] sum;
            logic [4:0] nib;
            logic [7:0] adj;
            logic       ci;
            o.value    = a;
            o.write_en = 1'b1;
            o.flags    = f;
            case (code)
                ACT_ADD, ACT_ADC:
                begin
                    ci               = (code == ACT_ADC) ? f.carry : 1'b0;
                    sum              = {1'b0, a} + {1'b0, b} + {8'd0, ci};
                    nib              = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, ci};
                    o.value          = sum[7:0];
                    o.flags.zero     = (sum[7:0] == 8'd0);
                    o.flags.subtract = 1'b0;
                    o.flags.half     = nib[4];
                    o.flags.carry    = sum[8];
                end
                ACT_SUB, ACT_CP:
                begin
                    o.value          = a - b;
                    o.flags.zero     = (o.value == 8'd0);
                    o.flags.subtract = 1'b1;
                    o.flags.half     = (a[3:0] < b[3:0]);
                    o.flags.carry    = (a < b);
                    // compare leaves the accumulator alone
                    if (code == ACT_CP)
                    begin
                        o.value    = a;
                        o.write_en = 1'b0;
                    end
                end
                ACT_AND, ACT_OR, ACT_XOR:
                begin
                    o.value          = (code == ACT_AND) ? (a & b) :
                                       (code == ACT_OR)  ? (a | b) : (a ^ b);
                    o.flags.zero     = (o.value == 8'd0);
                    o.flags.subtract = 1'b0;
                    o.flags.half     = (code == ACT_AND);
                    o.flags.carry    = 1'b0;
                end
                ACT_INC:
                begin
                    o.value          = b + 8'd1;
                    o.flags.zero     = (o.value == 8'd0);
                    o.flags.subtract = 1'b0;
                    o.flags.half     = (b[3:0] == 4'hF);
                end
                ACT_DEC:
                begin
                    o.value          = b - 8'd1;
                    o.flags.zero     = (o.value == 8'd0);
                    o.flags.subtract = 1'b1;
                    o.flags.half     = (b[3:0] == 4'h0);
                end
                ACT_DAA:
                begin
                    adj = 8'd0;
                    if (f.subtract)
                    begin
                        // after a subtract: undo only what the flags ask for
                        if (f.half)
                            adj = adj + DAA_LOW_ADJ;
                        if (f.carry)
                            adj = adj + DAA_HIGH_ADJ;
                        o.value = a - adj;
                    end
                    else
                    begin
                        if (f.half || a[3:0] > DAA_LOW_MAX)
                            adj = adj + DAA_LOW_ADJ;
                        if (f.carry || a > DAA_HIGH_MAX)
                        begin
                            adj           = adj + DAA_HIGH_ADJ;
                            o.flags.carry = 1'b1;
                        end
                        o.value = a + adj;
                    end
                    o.flags.zero = (o.value == 8'd0);
                    o.flags.half = 1'b0;
                end
                ACT_CPL:
                begin
                    o.value          = ~a;
                    o.flags.subtract = 1'b1;
                    o.flags.half     = 1'b1;
                end
                ACT_SCF:
                begin
                    o.write_en       = 1'b0;
                    o.flags.subtract = 1'b0;
                    o.flags.half     = 1'b0;
                    o.flags.carry    = 1'b1;
                end
                ACT_RLCA:
                begin
                    o.value = {a[6:0], a[7]};
                    o.flags = '{carry: a[7], half: 1'b0, subtract: 1'b0, zero: 1'b0};
                end
                ACT_RRA:
                begin
                    o.value = {f.carry, a[7:1]};
                    o.flags = '{carry: a[0], half: 1'b0, subtract: 1'b0, zero: 1'b0};
                end
                ACT_RR, ACT_SRL:
                begin
                    o.value = {(code == ACT_RR) ? f.carry : 1'b0, b[7:1]};
                    o.flags = '{carry: b[0], half: 1'b0, subtract: 1'b0,
                                zero: (o.value == 8'd0)};
                end
                ACT_SWAP:
                begin
                    o.value = {b[3:0], b[7:4]};
                    o.flags = '{carry: 1'b0, half: 1'b0, subtract: 1'b0,
                                zero: (o.value == 8'd0)};
                end
                default:
                    o.write_en = 1'b0;
            endcase
            return o;
        endfunction

        function void note_operation(logic [4:0] code, logic [7:0] a, logic [7:0] b,
                                     flags_t f);
            words_in++;
            op_seen[code] = 1'b1;
            if (code >= ACT_SPARE_LO)
                spare_codes++;
            awaited.push_back(alu_predict(code, a, b, f));
        endfunction

        function void check_result(logic [15:0] word);
            outcome_t got;
            outcome_t want;
            got.value    = word[7:0];
            got.write_en = word[8];
            got.flags    = flags_t'(word[12:9]);
            results_seen++;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: unexpected result word %h", $time, word);
                return;
            end
            want = awaited.pop_front();
            if (got.value !== want.value || got.write_en !== want.write_en ||
                got.flags.zero !== want.flags.zero ||
                got.flags.subtract !== want.flags.subtract ||
                got.flags.half !== want.flags.half ||
                got.flags.carry !== want.flags.carry)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: result %0d: expected val=%h we=%b CHNZ=%b, got val=%h we=%b CHNZ=%b",
                             $time, results_seen, want.value, want.write_en, want.flags,
                             got.value, got.write_en, got.flags);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [4:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    alu_result_ledger ledger = new();
    bit               long_hold_req = 1'b0;
    int               long_holds_done = 0;
    int               quiet_cycles = 0;

    eight_bit_alu_with_flags u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Offer one word and hold it until the block takes it
    task automatic send_op(logic [4:0] code, logic [7:0] a, logic [7:0] b,
                           logic [3:0] chnz);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= code;
        s_axis_tdata  <= {4'b0000, chnz, b, a};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Drop valid for a number of cycles
    task automatic idle_input(int cycles);
        if (cycles > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Bias operands toward nibble and carry boundaries
    function automatic logic [7:0] pick_byte();
        logic [7:0] corners[8] = '{8'h00, 8'hFF, 8'h0F, 8'h10, 8'h99, 8'h9A, 8'hF0, 8'h80};
        if ($urandom_range(0, 3) == 0)
            return corners[$urandom_range(0, 7)];
        return 8'($urandom);
    endfunction

    function automatic logic [4:0] pick_code();
        if ($urandom_range(0, 19) == 0)
            return 5'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
        return 5'($urandom_range(ACT_ADD, ACT_SWAP));
    endfunction

    // Track accepted words on both sides and watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                ledger.note_operation(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8],
                                      flags_t'(s_axis_tdata[19:16]));
            if (m_axis_tvalid && m_axis_tready)
                ledger.check_result(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no word moved for %0d cycles", quiet_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Output side: ready runs and stalls, plus one long hold on request
    initial
    begin
        int run;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_req = 1'b0;
                long_holds_done++;
            end
            else
            begin
                run = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
                m_axis_tready <= 1'b1;
                repeat (run) @(posedge clk);
                if ($urandom_range(0, 3) != 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat ($urandom_range(1, 5)) @(posedge clk);
                end
            end
        end
    end

    // Input side: directed corners, then random bursts
    initial
    begin
        int burst;
        int sent;
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // flags given as {C, H, N, Z}
        send_op(ACT_ADD,  8'hFF, 8'h01, 4'b0000);
        send_op(ACT_ADD,  8'h00, 8'h00, 4'b1111);
        send_op(ACT_ADC,  8'h0F, 8'h00, 4'b1000);
        send_op(ACT_ADC,  8'hFF, 8'hFF, 4'b1000);
        idle_input(2);
        send_op(ACT_SUB,  8'h00, 8'h01, 4'b0000);
        send_op(ACT_SUB,  8'h55, 8'h55, 4'b1110);
        send_op(ACT_CP,   8'h10, 8'h01, 4'b0001);
        send_op(ACT_AND,  8'hF0, 8'h0F, 4'b1010);
        send_op(ACT_OR,   8'h00, 8'h00, 4'b1110);
        send_op(ACT_XOR,  8'hAA, 8'h55, 4'b0001);
        idle_input(1);
        // inc and dec keep carry
        send_op(ACT_INC,  8'h00, 8'hFF, 4'b1000);
        send_op(ACT_DEC,  8'h00, 8'h00, 4'b1001);
        send_op(ACT_DEC,  8'hFF, 8'h01, 4'b0000);
        // decimal adjust: high correction sets carry, subtract mode keeps it
        send_op(ACT_DAA,  8'h9A, 8'h00, 4'b0000);
        send_op(ACT_DAA,  8'h00, 8'h00, 4'b1110);
        send_op(ACT_DAA,  8'h15, 8'h00, 4'b0100);
        send_op(ACT_CPL,  8'h00, 8'h00, 4'b1001);
        send_op(ACT_SCF,  8'h3C, 8'hFF, 4'b0111);
        // accumulator rotates clear zero even on a zero result
        send_op(ACT_RLCA, 8'h80, 8'h00, 4'b0001);
        send_op(ACT_RRA,  8'h01, 8'h00, 4'b0001);
        send_op(ACT_RR,   8'hFF, 8'h01, 4'b0000);
        send_op(ACT_SRL,  8'h00, 8'hFF, 4'b1111);
        send_op(ACT_SWAP, 8'hFF, 8'h00, 4'b1110);
        // spare codes pass everything through
        send_op(ACT_SPARE_LO, 8'h5A, 8'hA5, 4'b1010);
        send_op(ACT_SPARE_HI, 8'hFF, 8'hFF, 4'b1111);
        idle_input(3);

        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < RANDOM_WORDS; k++)
            begin
                if (sent == HOLD_AT_WORD)
                    long_hold_req = 1'b1;
                if (sent == DRAIN_AT_WORD)
                begin
                    // pause until every outstanding result is back
                    s_axis_tvalid <= 1'b0;
                    do
                        @(posedge clk);
                    while (ledger.awaited.size() != 0);
                end
                send_op(pick_code(), pick_byte(), pick_byte(), 4'($urandom));
                sent++;
            end
            idle_input(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
        end
        s_axis_tvalid <= 1'b0;

        // drain, then let the pipeline settle
        do
            @(posedge clk);
        while (ledger.awaited.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d words over all 17 operations (%0d on spare codes), %0d results checked",
                 ledger.words_in, ledger.spare_codes, ledger.results_seen);
        $display("Included %0d long output hold(s), a full drain pause, %0d mismatches, %0d left over",
                 long_holds_done, ledger.mismatches, ledger.awaited.size());
        if (ledger.mismatches == 0 && ledger.awaited.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
